### rtl/rwac_pkg.sv
`default_nettype none

package rwac_pkg;

  // Link class codes as reported in link_class.
  localparam logic [1:0] CLASS_STRONG = 2'd0;
  localparam logic [1:0] CLASS_WEAK   = 2'd1;
  localparam logic [1:0] CLASS_MEDIUM = 2'd2;

  // Number of earlier items needed before a class is reported.
  localparam logic [2:0] CLASS_AFTER = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_STRONG_THRESHOLD = 1'b0;
  localparam logic CFG_WEAK_THRESHOLD   = 1'b1;

  typedef struct packed {
    logic [1:0]        link_class;
    logic              class_valid;
    logic signed [7:0] avg_tx;
    logic signed [7:0] avg_rx;
  } result_t;

  // Control handed from the top level to the merging stage.
  typedef struct packed {
    logic load;
    logic class_en;
  } merge_ctrl_t;

endpackage

`default_nettype wire

### rtl/rssi_window_average_classifier_unit.sv
`default_nettype none

// RSSI window averager and link classifier. Each input transfer carries a
// received and a peer-reported RSSI sample; each produces one output transfer
// with both window averages (sum over the last WINDOW samples divided by
// WINDOW, truncated toward zero) and, from the sixth item on, a link class.
// The first sample pair after reset fills the whole window. The block takes
// one item per clock cycle while the output is not stalled. Each input is
// registered into the lane sums, then the reciprocal products, then the result
// register that drives m_tvalid. The block holds up to three items; once they
// back up behind a stalled output, s_tready stays low. Each sample stream has
// its own lane holding a shift line and a running sum, followed by a reciprocal
// multiply stage; a merging stage compares both averages to the thresholds and
// holds the result register.
module rssi_window_average_classifier_unit
  import rwac_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [7:0]  cfg_wdata,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [15:0] s_tdata,   // rx_rssi, tx_rssi
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [23:0] m_tdata   // avg_rx, avg_tx, class_valid, link_class, zero pad
);

  logic signed [7:0] strong_threshold;
  logic signed [7:0] weak_threshold;
  logic              primed;
  logic [2:0]        seen_count;
  logic              accept;
  logic              v1;
  logic              v1_cls;
  logic              v2;
  logic              v2_cls;
  logic              r2;
  logic              r_out;
  logic              stage_en;
  logic signed [7:0] avg_rx;
  logic signed [7:0] avg_tx;
  merge_ctrl_t       mctrl;
  result_t           result;

  always_ff @(posedge clk) begin
    if (rst) begin
      strong_threshold <= -8'sd60;
      weak_threshold   <= -8'sd90;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STRONG_THRESHOLD: strong_threshold <= cfg_wdata;
        CFG_WEAK_THRESHOLD:   weak_threshold   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign r_out    = !m_tvalid || m_tready;
  assign r2       = !v2 || r_out;
  assign s_tready = !v1 || r2;
  assign accept   = s_tvalid && s_tready;
  assign stage_en = v1 && r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      primed     <= 1'b0;
      seen_count <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
    end else begin
      if (accept) begin
        primed <= 1'b1;
        if (seen_count < CLASS_AFTER) begin
          seen_count <= seen_count + 3'd1;
        end
      end
      if (s_tready) begin
        v1 <= s_tvalid;
      end
      if (r2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v1_cls <= (seen_count >= CLASS_AFTER);
    end
    if (stage_en) begin
      v2_cls <= v1_cls;
    end
  end

  rwac_lane #(.WINDOW(WINDOW)) u_lane_rx (
    .clk      (clk),
    .load     (accept),
    .prime    (!primed),
    .sample   (s_tdata[7:0]),
    .stage_en (stage_en),
    .avg      (avg_rx)
  );

  rwac_lane #(.WINDOW(WINDOW)) u_lane_tx (
    .clk      (clk),
    .load     (accept),
    .prime    (!primed),
    .sample   (s_tdata[15:8]),
    .stage_en (stage_en),
    .avg      (avg_tx)
  );

  assign mctrl.load     = v2 && r_out;
  assign mctrl.class_en = v2_cls;

  rwac_merge u_merge (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (mctrl),
    .avg_rx           (avg_rx),
    .avg_tx           (avg_tx),
    .strong_threshold (strong_threshold),
    .weak_threshold   (weak_threshold),
    .out_ready        (m_tready),
    .out_valid        (m_tvalid),
    .result           (result)
  );

  assign m_tdata = {5'd0, result};

endmodule

`default_nettype wire

### rtl/rwac_lane.sv
`default_nettype none

module rwac_lane
  import rwac_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  wire               clk,
  input  wire               load,
  input  wire               prime,
  input  wire signed [7:0]  sample,
  input  wire               stage_en,
  output logic signed [7:0] avg
);

  localparam int LOG_W  = (WINDOW > 1) ? $clog2(WINDOW) : 0;
  localparam int SUM_W  = 8 + LOG_W;
  localparam int SHIFT  = SUM_W + LOG_W;
  localparam int MULT   = (2 ** SHIFT + WINDOW - 1) / WINDOW;
  localparam int MULT_W = $clog2(MULT + 1);
  localparam int PROD_W = SUM_W + MULT_W;

  logic signed [7:0]       ring [WINDOW];
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [SUM_W-1:0] sample_ext;
  logic signed [SUM_W-1:0] oldest_ext;
  logic signed [SUM_W-1:0] win_s;
  logic [SUM_W-1:0]        mag;
  logic [MULT_W-1:0]       mult_c;
  logic [PROD_W-1:0]       prod;
  logic                    neg;
  logic [7:0]              quot;

  assign sample_ext = SUM_W'(sample);
  assign oldest_ext = SUM_W'(ring[WINDOW-1]);
  assign win_s      = SUM_W'(WINDOW);
  assign mult_c     = MULT_W'(MULT);

  // The first sample after reset stands for a full window of itself.
  always_comb begin
    if (prime) begin
      sum_next = sample_ext * win_s;
    end else begin
      sum_next = sum - oldest_ext + sample_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum     <= sum_next;
      ring[0] <= sample;
    end
  end

  for (genvar i = 1; i < WINDOW; i++) begin : g_tap
    always_ff @(posedge clk) begin
      if (load) begin
        ring[i] <= prime ? sample : ring[i-1];
      end
    end
  end

  // Truncating division by WINDOW: exact reciprocal multiply on the magnitude.
  assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  always_ff @(posedge clk) begin
    if (stage_en) begin
      prod <= PROD_W'(mag) * PROD_W'(mult_c);
      neg  <= sum[SUM_W-1];
    end
  end

  assign quot = prod[SHIFT +: 8];
  assign avg  = neg ? 8'(-quot) : quot;

endmodule

`default_nettype wire

### rtl/rwac_merge.sv
`default_nettype none

module rwac_merge
  import rwac_pkg::*;
(
  input  wire               clk,
  input  wire               rst,
  input  merge_ctrl_t       ctrl,
  input  wire signed [7:0]  avg_rx,
  input  wire signed [7:0]  avg_tx,
  input  wire signed [7:0]  strong_threshold,
  input  wire signed [7:0]  weak_threshold,
  input  wire               out_ready,
  output logic              out_valid,
  output result_t           result
);

  logic [1:0] cls;

  always_comb begin
    if (!ctrl.class_en) begin
      cls = CLASS_STRONG;
    end else if (avg_rx > strong_threshold && avg_tx > strong_threshold) begin
      cls = CLASS_STRONG;
    end else if (avg_rx < weak_threshold || avg_tx < weak_threshold) begin
      cls = CLASS_WEAK;
    end else begin
      cls = CLASS_MEDIUM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      result.avg_rx      <= avg_rx;
      result.avg_tx      <= avg_tx;
      result.class_valid <= ctrl.class_en;
      result.link_class  <= cls;
    end
  end

endmodule

`default_nettype wire

### rtl/rwac_checker.sv
`default_nettype none

module rwac_checker
  import rwac_pkg::*;
(
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [23:0] m_tdata
);

  // A stalled result transfer keeps its value and stays offered.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transfer dropped or changed while stalled");

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Without a valid class the class code reads as zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[16] |-> m_tdata[18:17] == CLASS_STRONG)
    else $error("link class set while class not valid");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[18:17] == CLASS_STRONG || m_tdata[18:17] == CLASS_WEAK ||
                  m_tdata[18:17] == CLASS_MEDIUM) && m_tdata[23:19] == 5'd0)
    else $error("bad link class code or padding");

  // With the result register free, the block takes input.
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && s_tvalid && !s_tready |=> m_tvalid)
    else $error("input stalled with pipeline not backed up");

endmodule

bind rssi_window_average_classifier_unit rwac_checker u_rwac_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
